// ===== rtl/gca_pkg.sv =====
// shared types and constants of the glyph cache atlas allocator
package gca_pkg;

    // widths of the item fields
    localparam int FACE_W   = 8;
    localparam int SIZE_W   = 8;
    localparam int CP_W     = 21;
    localparam int PIX_W    = 13;
    localparam int MET_W    = 16;
    localparam int KEY_W    = FACE_W + SIZE_W + CP_W;
    localparam int KROW_W   = KEY_W + 1;
    localparam int REC_W    = 4 * PIX_W + 3 * MET_W;
    localparam int IN_W     = 112;
    localparam int OUT_W    = 104;
    localparam int OUSER_W  = 4;
    // hash value before reduction: ((255*31+255)*31 + 0x1fffff) fits in 22 bits
    localparam int HASH_W   = 22;

    // configuration register map
    localparam int          CFG_ADDR_W      = 3;
    localparam logic [2:0]  ADDR_ATLAS_SIDE = 3'd0;
    localparam logic [12:0] ATLAS_SIDE_RST  = 13'd1024;

    typedef enum logic [2:0] {
        ST_HIT        = 3'd0,
        ST_MISS       = 3'd1,
        ST_STORED     = 3'd2,
        ST_TABLE_FULL = 3'd3,
        ST_ATLAS_FULL = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        F_NONE = 2'd0,
        F_FREE = 2'd1,
        F_HIT  = 2'd2,
        F_FULL = 2'd3
    } t_found;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_REDUCE,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_DECIDE,
        S_PLACE1,
        S_PLACE2,
        S_STORE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic clear;
        logic capture;
        logic hash;
        logic reduce;
        logic probe_init;
        logic probe_rd;
        logic probe_chk;
        logic decide;
        logic place1;
        logic place2;
        logic store;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic reduce_done;
        logic probe_end;
        logic found_hit;
        logic kind;
        logic empty;
        logic fits;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/glyph_cache_atlas_allocator_top.sv =====
// top level of the glyph cache with shelf-packing atlas allocator
//
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+------------------------------------------
//  s_axis   | in        | tvalid / tready  | lookup or fill word, tuser = kind
//  m_axis   | out       | tvalid / tready  | placement word, tuser = status, upload
//  apb      | in        | psel/penable     | atlas_side register at byte address 0
//
//  one word at a time: accept in idle, hash, then the modulo reduction steps
//  (reciprocal multiply, back-multiply and subtract, one correction, probe start),
//  then a read state and a check state per probed slot, set by the registered key ram read,
//  then decide, shelf packing, store and output load as the word needs them
//  after reset a clearing pass over every key slot marks each slot unused;
//  s_axis_tready stays low during it, configuration writes are still taken
//  the output register lets the next word be accepted while a result waits;
//  a finished result stalls only if the previous one has not been taken
module glyph_cache_atlas_allocator_top #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // face_id, pixel_size, codepoint, bitmap_width, bitmap_rows,
    // raster_advance, raster_left, raster_top, zero pad
    input  logic [111:0]  s_axis_tdata,
    // kind
    input  logic [0:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // atlas_x, atlas_y, glyph_width, glyph_height, offset_x, offset_y,
    // pen_advance, zero pad
    output logic [103:0]  m_axis_tdata,
    // status, upload
    output logic [3:0]    m_axis_tuser,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import gca_pkg::*;

    logic [PIX_W-1:0] r_atlas_side;
    t_cmd  cmd;
    t_stat stat;

    // configuration register, written in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atlas_side <= ATLAS_SIDE_RST;
        end else if (psel && penable && pwrite && paddr == ADDR_ATLAS_SIDE) begin
            r_atlas_side <= pwdata[PIX_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_ATLAS_SIDE) ? {{(32 - PIX_W){1'b0}}, r_atlas_side} : '0;

    gca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    gca_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_atlas_side (r_atlas_side),
        .i_in_data    (s_axis_tdata),
        .i_in_kind    (s_axis_tuser[0]),
        .o_out_data   (m_axis_tdata),
        .o_out_user   (m_axis_tuser),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready)
    );

    // ready only in idle, one word in flight
    assign s_axis_tready = cmd.in_ready;
endmodule

// ===== rtl/gca_ram.sv =====
// generic single write port ram with registered read
module gca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/gca_ctrl.sv =====
// sequencing state machine of the glyph cache
module gca_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  gca_pkg::t_stat i_stat,
    output gca_pkg::t_cmd  o_cmd
);
    import gca_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_HASH;
                end
            end
            S_HASH: begin
                o_cmd.hash = 1'b1;
                n_state    = S_REDUCE;
            end
            S_REDUCE: begin
                if (i_stat.reduce_done) begin
                    o_cmd.probe_init = 1'b1;
                    n_state          = S_PROBE_RD;
                end else begin
                    o_cmd.reduce = 1'b1;
                end
            end
            S_PROBE_RD: begin
                o_cmd.probe_rd = 1'b1;
                n_state        = S_PROBE_CHK;
            end
            S_PROBE_CHK: begin
                o_cmd.probe_chk = 1'b1;
                n_state = i_stat.probe_end ? S_DECIDE : S_PROBE_RD;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                if (i_stat.found_hit || !i_stat.kind) n_state = S_OUT;
                else if (i_stat.empty)                n_state = S_STORE;
                else                                  n_state = S_PLACE1;
            end
            S_PLACE1: begin
                o_cmd.place1 = 1'b1;
                n_state      = S_PLACE2;
            end
            S_PLACE2: begin
                o_cmd.place2 = 1'b1;
                n_state      = i_stat.fits ? S_STORE : S_OUT;
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end
endmodule

// ===== rtl/gca_dp.sv =====
// datapath: hash, probe, shelf packer, stores and output register
module gca_dp #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  gca_pkg::t_cmd            i_cmd,
    output gca_pkg::t_stat           o_stat,
    input  logic [12:0]              i_atlas_side,
    input  logic [gca_pkg::IN_W-1:0] i_in_data,
    input  logic                     i_in_kind,
    output logic [gca_pkg::OUT_W-1:0]   o_out_data,
    output logic [gca_pkg::OUSER_W-1:0] o_out_user,
    output logic                     o_out_valid,
    input  logic                     i_out_ready
);
    import gca_pkg::*;

    localparam int AW     = $clog2(TABLE_DEPTH);
    localparam int RSH    = HASH_W + AW;
    localparam int RCP_W  = HASH_W + 1;
    localparam int RSTEPS = 3;
    localparam int SW     = $clog2(RSTEPS + 1);
    localparam logic [AW-1:0]     LAST_ADDR = AW'(TABLE_DEPTH - 1);
    localparam logic [HASH_W-1:0] DEPTH_H   = HASH_W'(TABLE_DEPTH);
    // floor(2^RSH / depth): quotient estimate is exact or one short
    localparam logic [RCP_W-1:0]  RECIP     = RCP_W'((64'd1 << RSH) / TABLE_DEPTH);

    // captured item
    logic              r_kind;
    logic [FACE_W-1:0] r_face;
    logic [SIZE_W-1:0] r_size;
    logic [CP_W-1:0]   r_cp;
    logic [PIX_W-1:0]  r_bw, r_bh;
    logic signed [MET_W-1:0] r_adv, r_left, r_top;

    // hash reduction and probe
    logic [HASH_W-1:0] r_rem, r_quo;
    logic [SW-1:0]     r_step;
    logic [AW-1:0]     r_addr, r_cnt, r_clr_addr;
    t_found            r_found;

    // shelf state and placement result
    logic [PIX_W-1:0] r_sx, r_sy, r_sh;
    logic [PIX_W-1:0] r_px, r_py, r_pw, r_ph;
    logic signed [MET_W-1:0] r_pl, r_pt;
    logic    r_upload;
    t_status r_status;

    logic [OUT_W-1:0]   r_out_data;
    logic [OUSER_W-1:0] r_out_user;
    logic               r_out_valid;

    logic [HASH_W-1:0] face_x, mid, hash;
    logic [HASH_W+RCP_W-1:0] recip_prod;
    logic [HASH_W-1:0] quo_mul;
    logic [KROW_W-1:0] key_rd, key_wd;
    logic [REC_W-1:0]  rec_rd, rec_wd;
    logic              key_we, rec_we, hit, free, last;
    logic [PIX_W:0]    row_sum, col_sum;
    logic              fits;
    logic [MET_W-1:0]  adv_sel;

    always_comb begin
        face_x = HASH_W'(r_face);
        mid    = (face_x << 5) - face_x + HASH_W'(r_size);
        hash   = (mid << 5) - mid + HASH_W'(r_cp);
    end

    // modulo by reciprocal multiplication, then back-multiply and one correction
    assign recip_prod = r_rem * RECIP;
    assign quo_mul    = r_quo * DEPTH_H;

    assign hit  = key_rd[KROW_W-1] && (key_rd[KEY_W-1:0] == {r_face, r_size, r_cp});
    assign free = !key_rd[KROW_W-1];
    assign last = (r_cnt == LAST_ADDR);

    assign col_sum = {1'b0, r_sx} + {1'b0, r_bw};
    assign row_sum = {1'b0, r_sy} + {1'b0, r_bh};
    assign fits    = row_sum <= {1'b0, i_atlas_side};

    assign key_we = i_cmd.clear || (i_cmd.store && r_found == F_FREE);
    assign key_wd = i_cmd.clear ? '0 : {1'b1, r_face, r_size, r_cp};
    assign rec_we = i_cmd.store && r_found == F_FREE;
    assign rec_wd = {r_adv, r_pt, r_pl, r_ph, r_pw, r_py, r_px};

    gca_ram #(.WIDTH(KROW_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (i_cmd.clear ? r_clr_addr : r_addr),
        .i_wdata (key_wd),
        .i_re    (i_cmd.probe_rd),
        .i_raddr (r_addr),
        .o_rdata (key_rd)
    );

    gca_ram #(.WIDTH(REC_W), .DEPTH(TABLE_DEPTH)) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (rec_we),
        .i_waddr (r_addr),
        .i_wdata (rec_wd),
        .i_re    (i_cmd.probe_rd),
        .i_raddr (r_addr),
        .o_rdata (rec_rd)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_sx        <= '0;
            r_sy        <= '0;
            r_sh        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) r_clr_addr <= r_clr_addr + 1'b1;
            if (i_cmd.place1 && col_sum > {1'b0, i_atlas_side}) begin
                r_sx <= '0;
                r_sy <= r_sy + r_sh;
                r_sh <= '0;
            end
            if (i_cmd.place2 && fits) begin
                r_sx <= col_sum[PIX_W-1:0];
                if (r_bh > r_sh) r_sh <= r_bh;
            end
            if (i_cmd.load_out)  r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_in_kind;
            r_face <= i_in_data[7:0];
            r_size <= i_in_data[15:8];
            r_cp   <= i_in_data[36:16];
            r_bw   <= i_in_data[49:37];
            r_bh   <= i_in_data[62:50];
            r_adv  <= i_in_data[78:63];
            r_left <= i_in_data[94:79];
            r_top  <= i_in_data[110:95];
        end
        if (i_cmd.hash) begin
            r_rem  <= hash;
            r_step <= '0;
        end
        if (i_cmd.reduce) begin
            case (r_step)
                SW'(0): r_quo <= HASH_W'(recip_prod >> RSH);
                SW'(1): r_rem <= r_rem - quo_mul;
                default: begin
                    if (r_rem >= DEPTH_H) r_rem <= r_rem - DEPTH_H;
                end
            endcase
            r_step <= r_step + 1'b1;
        end
        if (i_cmd.probe_init) begin
            r_addr  <= r_rem[AW-1:0];
            r_cnt   <= '0;
            r_found <= F_NONE;
        end
        if (i_cmd.probe_chk) begin
            if (hit)       r_found <= F_HIT;
            else if (free) r_found <= F_FREE;
            else if (last) r_found <= F_FULL;
            else begin
                r_addr <= (r_addr == LAST_ADDR) ? '0 : r_addr + 1'b1;
                r_cnt  <= r_cnt + 1'b1;
            end
        end
        if (i_cmd.decide) begin
            r_status <= (r_found == F_HIT) ? ST_HIT : ST_MISS;
            r_px     <= '0;
            r_py     <= '0;
            r_pw     <= '0;
            r_ph     <= '0;
            r_pl     <= '0;
            r_pt     <= '0;
            r_upload <= 1'b0;
        end
        if (i_cmd.place2) begin
            if (fits) begin
                r_px     <= r_sx;
                r_py     <= r_sy;
                r_pw     <= r_bw;
                r_ph     <= r_bh;
                r_pl     <= r_left;
                r_pt     <= r_top;
                r_upload <= 1'b1;
            end else begin
                r_status <= ST_ATLAS_FULL;
            end
        end
        if (i_cmd.store) begin
            r_status <= (r_found == F_FREE) ? ST_STORED : ST_TABLE_FULL;
        end
        if (i_cmd.load_out) begin
            if (r_status == ST_HIT) begin
                r_out_data <= {{(OUT_W - REC_W){1'b0}}, rec_rd};
            end else begin
                r_out_data <= {{(OUT_W - REC_W){1'b0}}, adv_sel, r_pt, r_pl,
                               r_ph, r_pw, r_py, r_px};
            end
            r_out_user <= {r_upload, r_status};
        end
    end

    assign adv_sel = (r_status == ST_STORED || r_status == ST_TABLE_FULL) ? r_adv : '0;

    always_comb begin
        o_stat             = '0;
        o_stat.clear_done  = (r_clr_addr == LAST_ADDR);
        o_stat.reduce_done = (r_step == SW'(RSTEPS));
        o_stat.probe_end   = hit || free || last;
        o_stat.found_hit   = (r_found == F_HIT);
        o_stat.kind        = r_kind;
        o_stat.empty       = (r_bw == '0) || (r_bh == '0);
        o_stat.fits        = fits;
        o_stat.out_free    = !r_out_valid || i_out_ready;
    end

    assign o_out_data  = r_out_data;
    assign o_out_user  = r_out_user;
    assign o_out_valid = r_out_valid;
endmodule

// ===== rtl/gca_checker.sv =====
// port-level assertions of the glyph cache, bound to the top level
module gca_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [103:0] m_axis_tdata,
    input logic [3:0]   m_axis_tuser
);
    import gca_pkg::*;

    // one word in flight: ready drops after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a word is in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser[2:0] <= ST_ATLAS_FULL)
        else $error("status code out of range");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[2:0] == ST_MISS || m_axis_tuser[2:0] == ST_ATLAS_FULL)
        |-> m_axis_tdata == '0 && !m_axis_tuser[3])
        else $error("miss or atlas full result carries data");

    a_upload_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[3]
        |-> m_axis_tuser[2:0] == ST_STORED || m_axis_tuser[2:0] == ST_TABLE_FULL)
        else $error("upload flagged on a result that packed nothing");
endmodule

bind glyph_cache_atlas_allocator_top gca_checker u_gca_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
